>>> rtl/core/sug_pkg.sv
// Shared types and codes for the span union gap segmenter.
package sug_pkg;

	typedef struct packed {
		logic ins;
		logic pop;
	} cell_ctrl_t;

	localparam logic REG_ROW_LEFT  = 1'b0;
	localparam logic REG_ROW_RIGHT = 1'b1;

endpackage

>>> rtl/core/sug_cell.sv
// One cell of the sorted span chain: holds one span, inserts or shifts with its neighbors.
module sug_cell #(
	parameter int COORD_BITS = 11
) (
	input  logic                         clk,
	input  sug_pkg::cell_ctrl_t          ctrl,
	input  logic                         occ,
	input  logic signed [COORD_BITS-1:0] new_l,
	input  logic signed [COORD_BITS-1:0] new_r,
	input  logic                         prev_shift,
	input  logic signed [COORD_BITS-1:0] prev_l,
	input  logic signed [COORD_BITS-1:0] prev_r,
	input  logic signed [COORD_BITS-1:0] next_l,
	input  logic signed [COORD_BITS-1:0] next_r,
	output logic                         shift,
	output logic signed [COORD_BITS-1:0] left,
	output logic signed [COORD_BITS-1:0] right
);
	import sug_pkg::*;

	logic signed [COORD_BITS-1:0] left_q;
	logic signed [COORD_BITS-1:0] right_q;
	logic                         ahead;

	// new span sorts ahead of the held one
	assign ahead = (new_l < left_q) || ((new_l == left_q) && (new_r < right_q));
	assign shift = occ && ahead;
	assign left  = left_q;
	assign right = right_q;

	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			left_q  <= next_l;
			right_q <= next_r;
		end else if (ctrl.ins) begin
			if (prev_shift) begin
				left_q  <= prev_l;
				right_q <= prev_r;
			end else if (!occ || ahead) begin
				left_q  <= new_l;
				right_q <= new_r;
			end
		end
	end

endmodule

>>> rtl/core/span_union_gap_segmenter.sv
// Top level of the span union gap segmenter: span chain, merge sequencer, output stage.
//
// Usage: a row's spans are offered one per transaction on start/busy; a transaction is
// taken at a clock edge with start high and busy low. Each span is clipped to
// [row_left, row_right) and, if non-empty, not skipped and the chain is not full, inserted
// into a sorted chain of MAX_SPANS cells in the same cycle, so busy stays low for non-final
// spans. A span with last_span set ends the row: busy rises and the chain shifts toward
// cell 0 one span per cycle, pausing as each run closes, as the sequencer merges runs and
// produces gap and occupied segments. Each segment appears for one cycle with seg_valid
// high; seg_final marks the last one. Each segment waits in a one-entry buffer until the
// next one is formed (or the closing cycle, for the last) and appears the cycle after;
// the last segment appears in the first cycle after busy falls. An empty row extent
// produces no segment. The receiver cannot stall; results must be taken as they come.
// Registers are written through cfg_valid/cfg_ready (always ready); the user must write
// them only while busy is low, which the block does not enforce. Reset clears the count,
// overflow flag, state and row extent; the chain content is loaded as spans arrive.
module span_union_gap_segmenter #(
	parameter int MAX_SPANS  = 16,
	parameter int COORD_BITS = 11
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic                         cfg_index,
	input  logic signed [COORD_BITS-1:0] cfg_data,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [COORD_BITS-1:0] span_left,
	input  logic signed [COORD_BITS-1:0] span_right,
	input  logic                         skip_span,
	input  logic                         last_span,
	output logic                         seg_valid,
	output logic signed [COORD_BITS-1:0] seg_left,
	output logic signed [COORD_BITS-1:0] seg_right,
	output logic                         seg_occupied,
	output logic                         seg_final,
	output logic                         span_overflow
);
	import sug_pkg::*;

	localparam int CNT_W = $clog2(MAX_SPANS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MERGE,
		ST_OCC,
		ST_TAIL,
		ST_FLUSH
	} state_t;

	state_t                       state_q;
	logic signed [COORD_BITS-1:0] row_left_q;
	logic signed [COORD_BITS-1:0] row_right_q;
	logic [CNT_W-1:0]             count_q;
	logic                         overflow_q;
	logic                         run_v_q;
	logic signed [COORD_BITS-1:0] ml_q;
	logic signed [COORD_BITS-1:0] mr_q;
	logic signed [COORD_BITS-1:0] cursor_q;
	logic                         pend_v_q;
	logic signed [COORD_BITS-1:0] pend_l_q;
	logic signed [COORD_BITS-1:0] pend_r_q;
	logic                         pend_occ_q;
	logic                         seg_valid_q;
	logic signed [COORD_BITS-1:0] seg_left_q;
	logic signed [COORD_BITS-1:0] seg_right_q;
	logic                         seg_occupied_q;
	logic                         seg_final_q;
	logic                         span_overflow_q;

	logic                         accept;
	logic signed [COORD_BITS-1:0] clip_l;
	logic signed [COORD_BITS-1:0] clip_r;
	logic                         kept;
	logic                         full;
	logic                         have;
	logic                         merge_hit;
	logic                         start_run;
	cell_ctrl_t                   ctrl;
	logic                         gen_v;
	logic signed [COORD_BITS-1:0] gen_l;
	logic signed [COORD_BITS-1:0] gen_r;
	logic                         gen_occ;

	logic signed [COORD_BITS-1:0] cell_l  [MAX_SPANS];
	logic signed [COORD_BITS-1:0] cell_r  [MAX_SPANS];
	logic                         cell_sh [MAX_SPANS];

	assign cfg_ready     = 1'b1;
	assign busy          = (state_q != ST_IDLE);
	assign accept        = start && !busy;
	assign seg_valid     = seg_valid_q;
	assign seg_left      = seg_left_q;
	assign seg_right     = seg_right_q;
	assign seg_occupied  = seg_occupied_q;
	assign seg_final     = seg_final_q;
	assign span_overflow = span_overflow_q;

	assign clip_l = (span_left > row_left_q) ? span_left : row_left_q;
	assign clip_r = (span_right < row_right_q) ? span_right : row_right_q;
	assign kept   = !skip_span && (clip_l < clip_r);
	assign full   = (count_q == CNT_W'(MAX_SPANS));
	assign have   = (count_q != '0);

	assign merge_hit = run_v_q && have && (cell_l[0] <= mr_q);
	assign start_run = !run_v_q && have;

	assign ctrl.ins = accept && kept && !full;
	assign ctrl.pop = (state_q == ST_MERGE) && (merge_hit || start_run);

	always_comb begin
		gen_v   = 1'b0;
		gen_l   = cursor_q;
		gen_r   = ml_q;
		gen_occ = 1'b0;
		unique case (state_q)
			ST_MERGE: begin
				if (run_v_q && !merge_hit) begin
					gen_v = (cursor_q < ml_q);
				end
			end
			ST_OCC: begin
				gen_v   = 1'b1;
				gen_l   = ml_q;
				gen_r   = mr_q;
				gen_occ = 1'b1;
			end
			ST_TAIL: begin
				gen_r = row_right_q;
				gen_v = (cursor_q < row_right_q);
			end
			ST_IDLE, ST_FLUSH: begin
				gen_v = 1'b0;
			end
			default: begin
				gen_v = 1'b0;
			end
		endcase
	end

	for (genvar i = 0; i < MAX_SPANS; i++) begin : g_cell
		logic                         occ;
		logic                         p_sh;
		logic signed [COORD_BITS-1:0] p_l;
		logic signed [COORD_BITS-1:0] p_r;
		logic signed [COORD_BITS-1:0] n_l;
		logic signed [COORD_BITS-1:0] n_r;

		assign occ = (count_q > CNT_W'(i));
		if (i == 0) begin : g_first
			assign p_sh = 1'b0;
			assign p_l  = clip_l;
			assign p_r  = clip_r;
		end else begin : g_mid
			assign p_sh = cell_sh[i-1];
			assign p_l  = cell_l[i-1];
			assign p_r  = cell_r[i-1];
		end
		if (i == MAX_SPANS - 1) begin : g_last
			assign n_l = cell_l[i];
			assign n_r = cell_r[i];
		end else begin : g_inner
			assign n_l = cell_l[i+1];
			assign n_r = cell_r[i+1];
		end

		sug_cell #(
			.COORD_BITS(COORD_BITS)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.occ       (occ),
			.new_l     (clip_l),
			.new_r     (clip_r),
			.prev_shift(p_sh),
			.prev_l    (p_l),
			.prev_r    (p_r),
			.next_l    (n_l),
			.next_r    (n_r),
			.shift     (cell_sh[i]),
			.left      (cell_l[i]),
			.right     (cell_r[i])
		);
	end

	// output stage and run bounds: registered results, no reset on payload
	always_ff @(posedge clk) begin
		if (gen_v) begin
			pend_l_q   <= gen_l;
			pend_r_q   <= gen_r;
			pend_occ_q <= gen_occ;
		end
		if ((gen_v || state_q == ST_FLUSH) && pend_v_q) begin
			seg_left_q      <= pend_l_q;
			seg_right_q     <= pend_r_q;
			seg_occupied_q  <= pend_occ_q;
			seg_final_q     <= (state_q == ST_FLUSH);
			span_overflow_q <= overflow_q;
		end
		if (state_q == ST_MERGE && start_run) begin
			ml_q <= cell_l[0];
			mr_q <= cell_r[0];
		end else if (merge_hit && cell_r[0] > mr_q) begin
			mr_q <= cell_r[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_left_q  <= '0;
			row_right_q <= '0;
			count_q     <= '0;
			overflow_q  <= 1'b0;
			run_v_q     <= 1'b0;
			cursor_q    <= '0;
			pend_v_q    <= 1'b0;
			seg_valid_q <= 1'b0;
		end else begin
			seg_valid_q <= pend_v_q && (gen_v || state_q == ST_FLUSH);
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_ROW_LEFT:  row_left_q  <= cfg_data;
					REG_ROW_RIGHT: row_right_q <= cfg_data;
					default: ;
				endcase
			end
			if (gen_v) begin
				pend_v_q <= 1'b1;
			end
			if (ctrl.pop) begin
				count_q <= count_q - CNT_W'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (ctrl.ins) begin
							count_q <= count_q + CNT_W'(1);
						end else if (kept && full) begin
							overflow_q <= 1'b1;
						end
						if (last_span) begin
							state_q  <= ST_MERGE;
							cursor_q <= row_left_q;
							run_v_q  <= 1'b0;
							pend_v_q <= 1'b0;
						end
					end
				end
				ST_MERGE: begin
					if (start_run) begin
						run_v_q <= 1'b1;
					end else if (run_v_q && !merge_hit) begin
						state_q <= ST_OCC;
					end else if (!run_v_q) begin
						state_q <= ST_TAIL;
					end
				end
				ST_OCC: begin
					cursor_q <= mr_q;
					run_v_q  <= 1'b0;
					state_q  <= ST_MERGE;
				end
				ST_TAIL: begin
					state_q <= ST_FLUSH;
				end
				ST_FLUSH: begin
					pend_v_q   <= 1'b0;
					count_q    <= '0;
					overflow_q <= 1'b0;
					state_q    <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> tb/tb_span_union_gap_segmenter.sv
// Testbench for span_union_gap_segmenter: directed and random rows checked by a scoreboard.
typedef logic signed [10:0] coord_t;

typedef struct {
	coord_t left;
	coord_t right;
	bit     occupied;
	bit     final_seg;
	bit     overflow;
} segment_t;

class segment_scoreboard;
	int       max_spans;
	int       row_l;
	int       row_r;
	int       lefts[$];
	int       rights[$];
	bit       overflow_seen;
	segment_t row_segs[$];
	segment_t expected[$];
	int       errors;

	function new(int max_spans);
		this.max_spans = max_spans;
		row_l = 0;
		row_r = 0;
		overflow_seen = 0;
		errors = 0;
	endfunction

	function void write_reg(logic idx, coord_t data);
		if (idx == sug_pkg::REG_ROW_LEFT) begin
			row_l = int'(data);
		end else begin
			row_r = int'(data);
		end
	endfunction

	function void add_segment(int l, int r, bit occ);
		segment_t s;
		if (l >= r)
			return;
		s.left = coord_t'(l);
		s.right = coord_t'(r);
		s.occupied = occ;
		s.final_seg = 1'b0;
		s.overflow = overflow_seen;
		row_segs = {row_segs, s};
	endfunction

	// accepted span transaction; on the last span the row's segments are queued
	function void note_span(coord_t a, coord_t b, bit skip, bit last);
		int l, r, i, j, n, kl, kr, cursor, ml, mr;
		if (!skip) begin
			l = (int'(a) > row_l) ? int'(a) : row_l;
			r = (int'(b) < row_r) ? int'(b) : row_r;
			if (l < r) begin
				if (lefts.size() < max_spans) begin
					lefts = {lefts, l};
					rights = {rights, r};
				end else begin
					overflow_seen = 1'b1;
				end
			end
		end
		if (!last)
			return;
		n = lefts.size();
		for (i = 1; i < n; i++) begin
			kl = lefts[i];
			kr = rights[i];
			j = i;
			while (j > 0 && (lefts[j-1] > kl || (lefts[j-1] == kl && rights[j-1] > kr))) begin
				lefts[j] = lefts[j-1];
				rights[j] = rights[j-1];
				j--;
			end
			lefts[j] = kl;
			rights[j] = kr;
		end
		cursor = row_l;
		i = 0;
		while (i < n) begin
			ml = lefts[i];
			mr = rights[i];
			i++;
			while (i < n && lefts[i] <= mr) begin
				if (rights[i] > mr)
					mr = rights[i];
				i++;
			end
			add_segment(cursor, ml, 1'b0);
			add_segment(ml, mr, 1'b1);
			cursor = mr;
		end
		add_segment(cursor, row_r, 1'b0);
		if (row_segs.size() > 0)
			row_segs[row_segs.size()-1].final_seg = 1'b1;
		foreach (row_segs[k])
			expected = {expected, row_segs[k]};
		row_segs.delete();
		lefts.delete();
		rights.delete();
		overflow_seen = 1'b0;
	endfunction

	function void check_segment(segment_t got);
		segment_t want;
		if (expected.size() == 0) begin
			$error("unexpected segment [%0d,%0d)", got.left, got.right);
			errors++;
			return;
		end
		want = expected.pop_front();
		if (got.left !== want.left) begin
			$error("seg_left: expected %0d, got %0d", want.left, got.left);
			errors++;
		end
		if (got.right !== want.right) begin
			$error("seg_right: expected %0d, got %0d", want.right, got.right);
			errors++;
		end
		if (got.occupied !== want.occupied) begin
			$error("seg_occupied: expected %0d, got %0d", want.occupied, got.occupied);
			errors++;
		end
		if (got.final_seg !== want.final_seg) begin
			$error("seg_final: expected %0d, got %0d", want.final_seg, got.final_seg);
			errors++;
		end
		if (got.overflow !== want.overflow) begin
			$error("span_overflow: expected %0d, got %0d", want.overflow, got.overflow);
			errors++;
		end
	endfunction
endclass

module tb_span_union_gap_segmenter;
	import sug_pkg::*;

	localparam int MAX_SPANS  = 16;
	localparam int COORD_BITS = 11;
	localparam int DRAIN_TAIL = 64;
	localparam int LIMIT      = 200000;
	localparam int RANDOM_ITEMS = 210;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   cfg_valid = 1'b0;
	logic   cfg_ready;
	logic   cfg_index = REG_ROW_LEFT;
	coord_t cfg_data = '0;
	logic   start = 1'b0;
	logic   busy;
	coord_t span_left = '0;
	coord_t span_right = '0;
	logic   skip_span = 1'b0;
	logic   last_span = 1'b0;
	logic   seg_valid;
	coord_t seg_left;
	coord_t seg_right;
	logic   seg_occupied;
	logic   seg_final;
	logic   span_overflow;

	segment_scoreboard sb;
	int cycles = 0;
	int items_sent = 0;
	int burst_left = 0;
	int ext_l = 0;
	int ext_r = 0;

	span_union_gap_segmenter #(
		.MAX_SPANS (MAX_SPANS),
		.COORD_BITS(COORD_BITS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.start        (start),
		.busy         (busy),
		.span_left    (span_left),
		.span_right   (span_right),
		.skip_span    (skip_span),
		.last_span    (last_span),
		.seg_valid    (seg_valid),
		.seg_left     (seg_left),
		.seg_right    (seg_right),
		.seg_occupied (seg_occupied),
		.seg_final    (seg_final),
		.span_overflow(span_overflow)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && sb != null) begin
			if (start && !busy)
				sb.note_span(span_left, span_right, skip_span, last_span);
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
			if (seg_valid)
				sb.check_segment('{seg_left, seg_right, seg_occupied, seg_final, span_overflow});
		end
	end

	function automatic int clamp_coord(int v);
		return (v < -1024) ? -1024 : (v > 1023) ? 1023 : v;
	endfunction

	task automatic send_span(int l, int r, bit skip, bit last);
		start <= 1'b1;
		span_left <= coord_t'(l);
		span_right <= coord_t'(r);
		skip_span <= skip;
		last_span <= last;
		do @(posedge clk); while (busy);
		items_sent++;
	endtask

	task automatic pace();
		burst_left--;
		if (burst_left <= 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 5);
		end
	endtask

	// idle until every expected segment has come and the block is free
	task automatic drain_all();
		start <= 1'b0;
		do @(posedge clk); while (sb.expected.size() != 0 || busy);
		repeat (DRAIN_TAIL) @(posedge clk);
	endtask

	task automatic set_extent(int l, int r);
		cfg_valid <= 1'b1;
		cfg_index <= REG_ROW_LEFT;
		cfg_data <= coord_t'(l);
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_ROW_RIGHT;
		cfg_data <= coord_t'(r);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		ext_l = l;
		ext_r = r;
	endtask

	task automatic random_span(bit last);
		int a, b;
		if ($urandom_range(7) == 0 || ext_l >= ext_r) begin
			a = coord_t'($urandom);
			b = coord_t'($urandom);
		end else begin
			a = clamp_coord(ext_l - 4 + int'($urandom_range(ext_r - ext_l + 7)));
			b = clamp_coord(a + int'($urandom_range(1 + (ext_r - ext_l) / 3)));
		end
		send_span(a, b, $urandom_range(9) == 0, last);
		pace();
	endtask

	task automatic random_row();
		int n;
		n = ($urandom_range(5) == 0) ? $urandom_range(14, 22) : $urandom_range(0, 7);
		repeat (n) random_span(1'b0);
		random_span(1'b1);
	endtask

	initial begin
		int phase, l, r;
		sb = new(MAX_SPANS);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// row extent still empty after reset: no segments
		send_span(-1024, 1023, 1'b0, 1'b1);
		drain_all();
		set_extent(-1024, 1023);
		send_span(-1024, 1023, 1'b0, 1'b1);
		send_span(0, 0, 1'b1, 1'b1);
		send_span(10, 20, 1'b0, 1'b0);
		send_span(20, 30, 1'b0, 1'b0);
		send_span(100, 50, 1'b0, 1'b0);
		send_span(500, 1023, 1'b1, 1'b0);
		send_span(-1024, -1000, 1'b0, 1'b1);
		drain_all();
		set_extent(-100, 100);
		send_span(-1024, -50, 1'b0, 1'b0);
		send_span(50, 1023, 1'b0, 1'b0);
		send_span(-1024, -100, 1'b0, 1'b1);
		drain_all();
		set_extent(500, -500);
		send_span(-600, 600, 1'b0, 1'b1);
		drain_all();
		set_extent(1022, 1023);
		send_span(1022, 1023, 1'b0, 1'b1);
		drain_all();

		items_sent = 0;
		phase = 0;
		while (items_sent < RANDOM_ITEMS) begin
			case (phase % 4)
				0: begin
					l = -1024;
					r = 1023;
				end
				1: begin
					l = int'($urandom_range(2047)) - 1024;
					r = clamp_coord(l + 1 + int'($urandom_range(60)));
				end
				2: begin
					l = int'($urandom_range(1000)) - 1024;
					r = clamp_coord(l + 200 + int'($urandom_range(1800)));
				end
				default: begin
					l = -1024;
					r = int'($urandom_range(2047)) - 1024;
				end
			endcase
			set_extent(l, r);
			repeat ($urandom_range(3, 8)) begin
				if (items_sent < RANDOM_ITEMS)
					random_row();
			end
			drain_all();
			phase++;
		end

		if (sb.errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

>>> span_union_gap_segmenter.f
rtl/core/sug_pkg.sv
rtl/core/sug_cell.sv
rtl/core/span_union_gap_segmenter.sv
tb/tb_span_union_gap_segmenter.sv
